>>> src/adjacency_matrix_graph_store_assert.svh
// Assertion helpers for the graph store, clocked on i_clk and held off in reset.
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_ASSERT_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define AMGS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define AMGS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AMGS_ASSERT_SAME(label, ante, cons, msg)

`define AMGS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> src/amgs_pkg.sv
package amgs_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int VTX_W        = 5;
    localparam int VC_W         = 6;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int ROW_W        = MAX_VERTICES;

    localparam logic [VC_W-1:0] VC_RESET = VC_W'(MAX_VERTICES);

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_SUCC = 2'd1;
    localparam logic [1:0] OP_PRED = 2'd2;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [VTX_W-1:0] source_vertex;
        logic [VTX_W-1:0] target_vertex;
    } t_in_item;

    typedef struct packed {
        logic [VTX_W-1:0] neighbor_vertex;
        logic             none_found;
        logic             last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_WR,
        S_ROW_LD,
        S_STREAM,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_src;
        logic add_wr;
        logic row_ld;
        logic stream;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       src_ok;
        logic       add_ok;
        logic       scan_done;
        logic       out_free;
    } t_stat;

endpackage

>>> src/adjacency_matrix_graph_store.sv
// Directed-graph store kept as a 32 x 32 adjacency bit matrix, one row per source vertex,
// cleared at reset. Each input item is an add-edge, a successor query or a predecessor query;
// queries answer with one item per neighbor in ascending order, the final one marked last, or a
// single none_found item when nothing matches or the vertex is outside vertex_count. Add-edge
// gives no result. Results leave one per cycle while the consumer keeps ready high. The scan
// visits one vertex per cycle, and for the predecessor query each step is a read of one row
// through the single read port of the row memory. A stalled output stalls the scan once a
// further vertex is found. The next item is taken once the final result of a query sits in the
// output register. vertex_count is written through i_cfg_we / i_cfg_wdata; the user must write it
// only while the block is idle, and the block itself does not enforce this. Values above 32 act
// as 32, zero leaves no vertex in range.
module adjacency_matrix_graph_store
    import amgs_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_in_item        i_in_item,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_out_item       o_out_item,
    input  logic            i_cfg_we,
    input  logic [VC_W-1:0] i_cfg_wdata
);

    t_cmd  cmd;
    t_stat stat;

    // Sequence each item: decode, row access, scan, final result.
    amgs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Hold the matrix, the count register, the scan pipeline and the output register.
    amgs_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

`include "adjacency_matrix_graph_store_assert.svh"

    // An empty answer carries a zero vertex and closes its run.
    `AMGS_ASSERT_SAME(a_none_is_last, o_out_valid && o_out_item.none_found,
        o_out_item.last && (o_out_item.neighbor_vertex == '0),
        "none_found item without last or with a vertex")

    // Add-edge never produces a result.
    `AMGS_ASSERT_NEXT(a_add_silent,
        i_in_valid && o_in_ready && (i_in_item.opcode == OP_ADD) && !o_out_valid,
        !o_out_valid, "add-edge produced a result")

    // Leaving the final step of a query leaves its closing item in the output register.
    `AMGS_ASSERT_SAME(a_finish_pushes, $rose(o_in_ready) && $past(cmd.finish),
        o_out_valid && o_out_item.last, "query ended without a last item")

endmodule

>>> src/amgs_ctrl.sv
module amgs_ctrl
    import amgs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.rd_src = 1'b1;
                case (i_stat.op)
                    OP_ADD:  n_state = i_stat.add_ok ? S_ADD_WR : S_IDLE;
                    OP_SUCC: n_state = i_stat.src_ok ? S_ROW_LD : S_FINISH;
                    OP_PRED: n_state = i_stat.src_ok ? S_STREAM : S_FINISH;
                    default: n_state = S_IDLE;
                endcase
            end
            S_ADD_WR: begin
                o_cmd.add_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_ROW_LD: begin
                o_cmd.row_ld = 1'b1;
                n_state      = S_STREAM;
            end
            S_STREAM: begin
                o_cmd.stream = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/amgs_dpath.sv
module amgs_dpath
    import amgs_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_in_item        i_in_item,
    input  logic            i_cfg_we,
    input  logic [VC_W-1:0] i_cfg_wdata,
    input  t_cmd            i_cmd,
    output t_stat           o_stat,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_out_item       o_out_item
);

    logic [VC_W-1:0]   r_vcount;
    logic [1:0]        r_op;
    logic [VTX_W-1:0]  r_src;
    logic [VTX_W-1:0]  r_dst;

    logic [ROW_W-1:0]  r_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_row_vld;
    logic [ROW_W-1:0]  r_rdata;
    logic              r_rd_vld;
    logic [ROW_W-1:0]  r_row;

    logic [CNT_W-1:0]  r_idx;
    logic              r_q_vld;
    logic [VTX_W-1:0]  r_q_idx;
    logic              r_pend_vld;
    logic [VTX_W-1:0]  r_pend_idx;

    logic              r_out_valid;
    t_out_item         r_out;

    logic [CNT_W-1:0]  n_use;
    logic [VTX_W-1:0]  rd_addr;
    logic [ROW_W-1:0]  rd_row;
    logic              q_hit;
    logic              out_free;
    logic              adv;
    logic              step;
    logic              push_hit;
    logic              push_fin;
    logic              idx_in;

    // Saturate the configured count to the matrix size.
    assign n_use = (r_vcount > VC_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : CNT_W'(r_vcount);

    assign rd_row   = r_rd_vld ? r_rdata : '0;
    assign q_hit    = (r_op == OP_SUCC) ? r_row[r_q_idx] : rd_row[r_src];
    assign out_free = !r_out_valid || i_out_ready;
    // Stall the scan only when a found vertex must displace the held one.
    assign adv      = out_free || !(r_q_vld && q_hit && r_pend_vld);
    assign step     = i_cmd.stream && adv;
    assign push_hit = step && r_q_vld && q_hit && r_pend_vld;
    assign push_fin = i_cmd.finish && out_free;
    assign idx_in   = r_idx < n_use;

    // Re-read the held row while stalled so data stays matched to its tag.
    always_comb begin
        if (i_cmd.rd_src) begin
            rd_addr = r_src;
        end else if (adv) begin
            rd_addr = r_idx[VTX_W-1:0];
        end else begin
            rd_addr = r_q_idx;
        end
    end

    always_comb begin
        o_stat.op        = r_op;
        o_stat.src_ok    = CNT_W'(r_src) < n_use;
        o_stat.add_ok    = (CNT_W'(r_src) < n_use) && (CNT_W'(r_dst) < n_use);
        o_stat.scan_done = !r_q_vld && !idx_in;
        o_stat.out_free  = out_free;
    end

    // Row memory: one read and one write port, registered read.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        if (i_cmd.add_wr) begin
            r_mem[r_src] <= rd_row | (ROW_W'(1) << r_dst);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_rd_vld <= r_row_vld[rd_addr];
            if (i_cmd.add_wr) begin
                r_row_vld[r_src] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VC_RESET;
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in_item.opcode;
            r_src <= i_in_item.source_vertex;
            r_dst <= i_in_item.target_vertex;
        end
        if (i_cmd.row_ld) begin
            r_row <= rd_row;
        end
        if (step) begin
            r_q_idx <= r_idx[VTX_W-1:0];
            if (r_q_vld && q_hit) begin
                r_pend_idx <= r_q_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_q_vld    <= 1'b0;
            r_pend_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx      <= '0;
            r_q_vld    <= 1'b0;
            r_pend_vld <= 1'b0;
        end else if (step) begin
            r_q_vld <= idx_in;
            if (idx_in) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (r_q_vld && q_hit) begin
                r_pend_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push_hit || push_fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_hit) begin
            r_out.neighbor_vertex <= r_pend_idx;
            r_out.none_found      <= 1'b0;
            r_out.last            <= 1'b0;
        end else if (push_fin) begin
            r_out.neighbor_vertex <= r_pend_vld ? r_pend_idx : '0;
            r_out.none_found      <= !r_pend_vld;
            r_out.last            <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
